// File: sv/muit_pkg.sv
// ----------------------------------------------------------------------------
// muit_pkg
// Shared types and constants of the multi-unit issue tracker.
// ----------------------------------------------------------------------------
package muit_pkg;

    localparam int MAX_UNITS = 4;
    localparam int MAX_DEPTH = 8;
    localparam int UW = $clog2(MAX_UNITS);
    localparam int DW = $clog2(MAX_DEPTH);
    localparam int SW = UW + DW;
    localparam int NSLOT = MAX_UNITS * MAX_DEPTH;
    localparam int CW = 48;
    localparam logic [CW-1:0] M48 = {CW{1'b1}};

    localparam logic [1:0] REG_UNITS = 2'd0;
    localparam logic [1:0] REG_PIPE  = 2'd1;
    localparam logic [1:0] REG_DEPTH = 2'd2;

    typedef struct packed {
        logic [31:0]   tag;
        logic [3:0]    cls;
        logic [CW-1:0] done;
    } t_slot;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD,
        ST_CHK,
        ST_ISSUE,
        ST_SUM
    } t_state;

endpackage

// File: sv/muit_slot_ram.sv
// ----------------------------------------------------------------------------
// muit_slot_ram
// Slot store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module muit_slot_ram
    import muit_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [SW-1:0] i_waddr,
    input  t_slot         i_wdata,
    input  logic [SW-1:0] i_raddr,
    output t_slot         o_rdata
);
    t_slot r_mem [NSLOT];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: sv/multi_unit_issue_tracker_core.sv
// ----------------------------------------------------------------------------
// multi_unit_issue_tracker_core
// Issue scoreboard with round-robin unit selection for one resource class.
// ----------------------------------------------------------------------------
// Each input transaction is one simulated cycle. The block walks the units in
// order, reading each queue head from the slot memory (a read state, then a compare
// state) and emitting one completion transaction per retired head; then
// it performs the round-robin issue and emits the summary transaction with
// last=1. An item passes idle, then read and compare for each unit scanned,
// again read and compare for each retirement, then issue and summary; the order
// is set by the single read port of the slot memory. While the output register
// is held by a stall the block waits; issue also waits until a pending
// result has left, so the
// counters of a stalled summary never change. Input is taken only in idle.
// Slot entries are read only after an issue wrote them, so no clearing pass.
module multi_unit_issue_tracker_core
    import muit_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    input  logic          i_valid,
    output logic          o_stall,
    input  logic [47:0]   i_cycle_now,
    input  logic          i_issue_request,
    input  logic [31:0]   i_instr_tag,
    input  logic [3:0]    i_instr_class,
    input  logic [15:0]   i_latency,
    output logic          o_valid,
    input  logic          i_stall,
    output logic          o_is_completion,
    output logic [31:0]   o_done_tag,
    output logic [3:0]    o_done_class,
    output logic          o_accepted,
    output logic [1:0]    o_chosen_unit,
    output logic [47:0]   o_busy_total,
    output logic [47:0]   o_stall_total,
    output logic [47:0]   o_issue_total,
    output logic [5:0]    o_peak_inflight,
    output logic          o_last
);
    // configuration
    logic [2:0] r_unit_count;
    logic       r_pipe;
    logic [3:0] r_depth;

    assign pready = 1'b1;
    always_comb begin
        unique case (paddr[3:2])
            REG_UNITS: prdata = {29'd0, r_unit_count};
            REG_PIPE:  prdata = {31'd0, r_pipe};
            REG_DEPTH: prdata = {28'd0, r_depth};
            default:   prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit_count <= 3'd1;
            r_pipe       <= 1'b0;
            r_depth      <= 4'd1;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                REG_UNITS: r_unit_count <= pwdata[2:0];
                REG_PIPE:  r_pipe       <= pwdata[0];
                REG_DEPTH: r_depth      <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    // latched input item
    logic [CW-1:0] r_now;
    logic          r_req;
    logic [31:0]   r_tag;
    logic [3:0]    r_cls;
    logic [15:0]   r_lat;

    // per-unit state (small, in flops)
    logic [CW-1:0] r_ready [MAX_UNITS];
    logic [DW:0]   r_fill  [MAX_UNITS];
    logic [DW-1:0] r_head  [MAX_UNITS];
    logic [UW-1:0] r_cursor;
    logic [CW-1:0] r_busy, r_stalls, r_issues;
    logic [5:0]    r_peak;

    t_state        r_state, n_state;
    logic [UW-1:0] r_u;

    // output register
    logic          r_ov;
    logic          r_oc;
    logic [31:0]   r_otag;
    logic [3:0]    r_ocls;
    logic          r_oacc;
    logic [1:0]    r_ochosen;

    // slot memory
    t_slot         w_rdata, w_wdata;
    logic          w_we;
    logic [SW-1:0] w_waddr, w_raddr;

    muit_slot_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_raddr = {r_u, r_head[r_u]};

    // effective unit count and depth
    logic [UW:0] w_units;
    logic [DW:0] w_dep;
    always_comb begin
        if (r_unit_count == 3'd0) w_units = (UW+1)'(1);
        else if (32'(r_unit_count) > MAX_UNITS) w_units = (UW+1)'(MAX_UNITS);
        else w_units = (UW+1)'(r_unit_count);
        if (r_depth == 4'd0) w_dep = (DW+1)'(1);
        else if (32'(r_depth) > MAX_DEPTH) w_dep = (DW+1)'(MAX_DEPTH);
        else w_dep = (DW+1)'(r_depth);
    end

    // round-robin search over MAX_UNITS candidates (independent checks)
    logic [15:0]   w_lat1;
    logic          w_found;
    logic [UW-1:0] w_chosen;
    logic [UW:0]   w_cur, w_c, w_nxt;
    always_comb begin
        w_lat1 = (r_lat == 16'd0) ? 16'd1 : r_lat;
        // cursor may sit above a lowered count: reduce it by repeated subtract
        w_cur = (UW+1)'(r_cursor);
        for (int j = 0; j < MAX_UNITS - 1; j++) begin
            if (w_cur >= w_units) w_cur = w_cur - w_units;
        end
        w_found = 1'b0;
        w_chosen = '0;
        w_c = '0;
        for (int k = 0; k < MAX_UNITS; k++) begin
            w_c = w_cur + (UW+1)'(k);
            if (w_c >= w_units) w_c = w_c - w_units;
            if (!w_found && (UW+1)'(k) < w_units &&
                r_ready[w_c[UW-1:0]] <= r_now &&
                (r_pipe ? (r_fill[w_c[UW-1:0]] < w_dep)
                        : (r_fill[w_c[UW-1:0]] == '0))) begin
                w_found = 1'b1;
                w_chosen = w_c[UW-1:0];
            end
        end
        // next cursor: chosen is below the count, so one wrap check
        w_nxt = (UW+1)'(w_chosen) + 1'b1;
        if (w_nxt >= w_units) w_nxt = '0;
    end

    function automatic logic [CW-1:0] add_sat(input logic [CW-1:0] a,
                                              input logic [15:0] b);
        logic [CW:0] s;
        s = {1'b0, a} + {{(CW-15){1'b0}}, b};
        return s[CW] ? M48 : s[CW-1:0];
    endfunction

    logic w_out_free;
    assign w_out_free = !r_ov || !i_stall;

    logic w_issue;
    assign w_issue = (r_state == ST_ISSUE) && w_out_free && r_req && w_found;
    assign w_we    = w_issue;
    assign w_waddr = {w_chosen, DW'(r_head[w_chosen] + r_fill[w_chosen][DW-1:0])};
    assign w_wdata = '{tag: r_tag, cls: r_cls, done: add_sat(r_now, w_lat1)};

    logic w_retire;
    assign w_retire = (r_state == ST_CHK) && (r_fill[r_u] != '0) &&
                      (w_rdata.done <= r_now);

    // a transaction enters the output register
    logic w_load;
    assign w_load = w_out_free && (w_retire || (r_state == ST_SUM));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (i_valid) n_state = ST_RD;
            ST_RD:    n_state = ST_CHK;
            ST_CHK: begin
                if (w_retire) begin
                    if (w_out_free) n_state = ST_RD;
                end else if (r_u == UW'(MAX_UNITS - 1)) begin
                    n_state = ST_ISSUE;
                end else begin
                    n_state = ST_RD;
                end
            end
            ST_ISSUE: if (w_out_free) n_state = ST_SUM;
            ST_SUM:   if (w_out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // outputs of the state machine
    always_comb begin
        o_stall = (r_state != ST_IDLE);
    end

    logic [DW+UW+1:0] w_total;
    logic             w_inflight;
    always_comb begin
        w_total = '0;
        w_inflight = 1'b0;
        for (int u = 0; u < MAX_UNITS; u++) begin
            w_total = w_total + (DW+UW+2)'(r_fill[u]);
            if (r_fill[u] != '0) w_inflight = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_u      <= '0;
            r_cursor <= '0;
            r_busy   <= '0;
            r_stalls <= '0;
            r_issues <= '0;
            r_peak   <= '0;
            r_ov     <= 1'b0;
            r_oacc   <= 1'b0;
            for (int u = 0; u < MAX_UNITS; u++) begin
                r_ready[u] <= '0;
                r_fill[u]  <= '0;
                r_head[u]  <= '0;
            end
        end else begin
            r_state <= n_state;
            if (w_load) r_ov <= 1'b1;
            else if (!i_stall) r_ov <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_now <= i_cycle_now;
                        r_req <= i_issue_request;
                        r_tag <= i_instr_tag;
                        r_cls <= i_instr_class;
                        r_lat <= i_latency;
                        r_u   <= '0;
                    end
                end
                ST_CHK: begin
                    if (w_retire) begin
                        if (w_out_free) begin
                            r_oc      <= 1'b1;
                            r_otag    <= w_rdata.tag;
                            r_ocls    <= w_rdata.cls;
                            r_oacc    <= 1'b0;
                            r_ochosen <= '0;
                            r_head[r_u] <= r_head[r_u] + 1'b1;
                            r_fill[r_u] <= r_fill[r_u] - 1'b1;
                        end
                    end else if (r_u != UW'(MAX_UNITS - 1)) begin
                        r_u <= r_u + 1'b1;
                    end
                end
                ST_ISSUE: begin
                    if (w_out_free) begin
                        r_oacc    <= w_issue;
                        r_ochosen <= w_issue ? 2'(w_chosen) : 2'd0;
                        if (w_issue) begin
                            r_fill[w_chosen]  <= r_fill[w_chosen] + 1'b1;
                            r_ready[w_chosen] <= add_sat(r_now, r_pipe ? 16'd1 : w_lat1);
                            if (r_issues != M48) r_issues <= r_issues + 1'b1;
                            if ((w_total + 1'b1) > (DW+UW+2)'(r_peak))
                                r_peak <= 6'(w_total + 1'b1);
                            r_cursor <= w_nxt[UW-1:0];
                        end else if (r_req && r_stalls != M48) begin
                            r_stalls <= r_stalls + 1'b1;
                        end
                        if ((w_inflight || w_issue) && r_busy != M48)
                            r_busy <= r_busy + 1'b1;
                    end
                end
                ST_SUM: begin
                    if (w_out_free) begin
                        r_oc   <= 1'b0;
                        r_otag <= '0;
                        r_ocls <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_valid         = r_ov;
    assign o_is_completion = r_oc;
    assign o_done_tag      = r_otag;
    assign o_done_class    = r_ocls;
    assign o_accepted      = r_oc ? 1'b0 : r_oacc;
    assign o_chosen_unit   = r_oc ? 2'd0 : r_ochosen;
    assign o_busy_total    = r_oc ? '0 : r_busy;
    assign o_stall_total   = r_oc ? '0 : r_stalls;
    assign o_issue_total   = r_oc ? '0 : r_issues;
    assign o_peak_inflight = r_oc ? '0 : r_peak;
    assign o_last          = !r_oc;
endmodule

// File: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the multi-unit issue tracker core. A local model of
// the unit queues, round-robin cursor and saturating counters predicts every
// completion and summary transaction; results are compared in order.
// ----------------------------------------------------------------------------
module tb_top;
    import muit_pkg::*;

    // one input item as queued for the driver
    typedef struct packed {
        logic [47:0] cyc;
        logic        req;
        logic [31:0] tag;
        logic [3:0]  cls;
        logic [15:0] lat;
    } t_tick;

    // one result transaction
    typedef struct packed {
        logic        is_cmp;
        logic [31:0] tag;
        logic [3:0]  cls;
        logic        acc;
        logic [1:0]  unit;
        logic [47:0] busy;
        logic [47:0] stall;
        logic [47:0] issue;
        logic [5:0]  peak;
        logic        last;
    } t_rec;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [47:0] i_cycle_now = '0;
    logic        i_issue_request = 1'b0;
    logic [31:0] i_instr_tag = '0;
    logic [3:0]  i_instr_class = '0;
    logic [15:0] i_latency = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic        o_is_completion;
    logic [31:0] o_done_tag;
    logic [3:0]  o_done_class;
    logic        o_accepted;
    logic [1:0]  o_chosen_unit;
    logic [47:0] o_busy_total, o_stall_total, o_issue_total;
    logic [5:0]  o_peak_inflight;
    logic        o_last;

    multi_unit_issue_tracker_core dut (.*);

    always #5 i_clk = ~i_clk;

    // ---------------- scoreboard model state ----------------
    int unsigned  m_units = 1, m_pipe = 0, m_depth = 1;
    logic [47:0]  m_ready [MAX_UNITS];
    logic [31:0]  m_tag   [NSLOT];
    logic [47:0]  m_done  [NSLOT];
    logic [3:0]   m_cls   [NSLOT];
    int unsigned  m_fill  [MAX_UNITS];
    int unsigned  m_head  [MAX_UNITS];
    int unsigned  m_cursor;
    logic [47:0]  m_busy, m_stalls, m_issues;
    logic [5:0]   m_peak;

    // pending ticks and expected records, ring buffers with running counts
    localparam int QDEPTH = 8192;
    t_tick tick_mem [QDEPTH];
    t_rec  rec_mem  [QDEPTH];
    int    tick_rd = 0, tick_wr = 0;
    int    rec_rd = 0, rec_wr = 0;

    int    errors = 0;
    int    n_cmp = 0, n_sum = 0, n_acc = 0;
    bit    idle_off = 1'b0;
    bit    done_flag = 1'b0;
    int    quiet = 0;

    function automatic logic [47:0] sat_add(logic [47:0] a, logic [47:0] b);
        logic [48:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[48] ? M48 : s[47:0];
    endfunction

    task automatic rec_put(t_rec r);
        rec_mem[rec_wr % QDEPTH] = r;
        rec_wr++;
    endtask

    // Advance the model by one simulated cycle and record the expected results.
    task automatic predict_tick(t_tick t);
        t_rec r;
        logic [15:0] lat;
        int unsigned depth, units, c, s, total, chosen;
        bit acc, busy;
        lat = (t.lat == 0) ? 16'd1 : t.lat;
        // retire heads in unit order
        for (int u = 0; u < MAX_UNITS; u++) begin
            while (m_fill[u] > 0) begin
                s = u * MAX_DEPTH + m_head[u];
                if (m_done[s] > t.cyc) break;
                r = '0;
                r.is_cmp = 1'b1;
                r.tag = m_tag[s];
                r.cls = m_cls[s];
                rec_put(r);
                m_head[u] = (m_head[u] + 1) % MAX_DEPTH;
                m_fill[u]--;
            end
        end
        acc = 0;
        chosen = 0;
        if (t.req) begin
            units = (m_units == 0) ? 1 : (m_units > MAX_UNITS ? MAX_UNITS : m_units);
            depth = (m_depth == 0) ? 1 : (m_depth > MAX_DEPTH ? MAX_DEPTH : m_depth);
            for (int k = 0; k < units && !acc; k++) begin
                c = (m_cursor % units + k) % units;
                if (m_ready[c] <= t.cyc &&
                    (m_pipe ? (m_fill[c] < depth) : (m_fill[c] == 0))) begin
                    acc = 1;
                    chosen = c;
                end
            end
            if (acc) begin
                s = chosen * MAX_DEPTH + (m_head[chosen] + m_fill[chosen]) % MAX_DEPTH;
                m_tag[s] = t.tag;
                m_cls[s] = t.cls;
                m_done[s] = sat_add(t.cyc, {32'd0, lat});
                m_fill[chosen]++;
                m_ready[chosen] = sat_add(t.cyc, m_pipe ? 48'd1 : {32'd0, lat});
                if (m_issues != M48) m_issues++;
                total = 0;
                foreach (m_fill[u]) total += m_fill[u];
                if (total > m_peak) m_peak = total[5:0];
                m_cursor = (chosen + 1) % units;
            end else if (m_stalls != M48) begin
                m_stalls++;
            end
        end
        busy = acc;
        foreach (m_fill[u]) if (m_fill[u] != 0) busy = 1;
        if (busy && m_busy != M48) m_busy++;
        r = '0;
        r.acc = acc;
        r.unit = chosen[1:0];
        r.busy = m_busy;
        r.stall = m_stalls;
        r.issue = m_issues;
        r.peak = m_peak;
        r.last = 1'b1;
        rec_put(r);
    endtask

    // APB write: setup then access, register lands at the access edge
    task automatic reg_write(logic [1:0] idx, logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_UNITS: m_units = val & 7;
            REG_PIPE:  m_pipe  = val & 1;
            REG_DEPTH: m_depth = val & 15;
            default: ;
        endcase
    endtask

    // wait until every queued tick is taken and every record has come back
    task automatic drain();
        while (tick_wr != tick_rd || rec_wr != rec_rd) @(posedge i_clk);
        repeat (2 * MAX_UNITS + 2 * NSLOT + 8) @(posedge i_clk);
    endtask

    // ---------------- driver ----------------
    int    gap_left = 0;
    t_tick cur;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && !o_stall) begin
            tick_rd++;
            if (tick_wr != tick_rd && (idle_off || $urandom_range(0, 9) != 0)) begin
                cur = tick_mem[tick_rd % QDEPTH];
                i_valid <= 1'b1;
                i_cycle_now <= cur.cyc; i_issue_request <= cur.req;
                i_instr_tag <= cur.tag; i_instr_class <= cur.cls; i_latency <= cur.lat;
            end else begin
                i_valid <= 1'b0;
                gap_left <= idle_off ? 0 : $urandom_range(0, 11);
            end
        end else if (!i_valid) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
            end else if (tick_wr != tick_rd) begin
                cur = tick_mem[tick_rd % QDEPTH];
                i_valid <= 1'b1;
                i_cycle_now <= cur.cyc; i_issue_request <= cur.req;
                i_instr_tag <= cur.tag; i_instr_class <= cur.cls; i_latency <= cur.lat;
            end
        end
    end

    // ---------------- receiver stall bursts ----------------
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_stall <= 1'b1;
        end else if (!idle_off && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 11);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // ---------------- monitor ----------------
    t_rec got, want;
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            got = {o_is_completion, o_done_tag, o_done_class, o_accepted, o_chosen_unit,
                   o_busy_total, o_stall_total, o_issue_total, o_peak_inflight, o_last};
            if (rec_wr == rec_rd) begin
                $display("%0t: unexpected record %h", $time, got);
                errors++;
            end else begin
                want = rec_mem[rec_rd % QDEPTH];
                rec_rd++;
                if (got.is_cmp) n_cmp++; else n_sum++;
                if (got.acc) n_acc++;
                if (got.is_cmp !== want.is_cmp) begin
                    $display("%0t: is_completion exp %h got %h", $time, want.is_cmp, got.is_cmp);
                    errors++;
                end
                if (got.tag !== want.tag) begin
                    $display("%0t: done_tag exp %h got %h", $time, want.tag, got.tag);
                    errors++;
                end
                if (got.cls !== want.cls) begin
                    $display("%0t: done_class exp %h got %h", $time, want.cls, got.cls);
                    errors++;
                end
                if (got.acc !== want.acc) begin
                    $display("%0t: accepted exp %h got %h", $time, want.acc, got.acc);
                    errors++;
                end
                if (got.unit !== want.unit) begin
                    $display("%0t: chosen_unit exp %h got %h", $time, want.unit, got.unit);
                    errors++;
                end
                if (got.busy !== want.busy) begin
                    $display("%0t: busy_total exp %h got %h", $time, want.busy, got.busy);
                    errors++;
                end
                if (got.stall !== want.stall) begin
                    $display("%0t: stall_total exp %h got %h", $time, want.stall, got.stall);
                    errors++;
                end
                if (got.issue !== want.issue) begin
                    $display("%0t: issue_total exp %h got %h", $time, want.issue, got.issue);
                    errors++;
                end
                if (got.peak !== want.peak) begin
                    $display("%0t: peak_inflight exp %h got %h", $time, want.peak, got.peak);
                    errors++;
                end
                if (got.last !== want.last) begin
                    $display("%0t: last exp %h got %h", $time, want.last, got.last);
                    errors++;
                end
            end
        end
    end

    // ---------------- watchdog ----------------
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || done_flag || (psel && penable))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet > 20000) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    logic [47:0] sim_cyc = '0;

    // queue one tick; the model is advanced at queue time since order is fixed
    task automatic add_tick(logic [47:0] cyc, logic req, logic [31:0] tag,
                            logic [3:0] cls, logic [15:0] lat);
        t_tick t;
        t = {cyc, req, tag, cls, lat};
        predict_tick(t);
        tick_mem[tick_wr % QDEPTH] = t;
        tick_wr++;
    endtask

    task automatic random_phase(int count, int unsigned maxlat);
        logic [15:0] lat;
        for (int i = 0; i < count; i++) begin
            // mostly small steps, sometimes a jump or a repeat
            case ($urandom_range(0, 9))
                0: ;
                1: sim_cyc = sat_add(sim_cyc, 48'($urandom_range(10, 300)));
                default: sim_cyc = sat_add(sim_cyc, 48'd1);
            endcase
            lat = ($urandom_range(0, 19) == 0) ? 16'($urandom) : 16'($urandom_range(0, maxlat));
            // latencies above 400 are either kept or raised to the maximum 16'hFFFF
            if (lat > 400) lat = 16'($urandom_range(0, 1) ? 16'hFFFF : lat);
            add_tick(sim_cyc, $urandom_range(0, 4) != 0, $urandom, 4'($urandom), lat);
        end
    endtask

    initial begin
        foreach (m_ready[u]) begin
            m_ready[u] = '0; m_fill[u] = 0; m_head[u] = 0;
        end
        m_cursor = 0; m_busy = '0; m_stalls = '0; m_issues = '0; m_peak = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: default config, one unit, blocking mode
        add_tick(48'd0, 1'b1, 32'hFFFF_FFFF, 4'hF, 16'd0);
        add_tick(48'd0, 1'b1, 32'h0, 4'h0, 16'd3);
        add_tick(48'd1, 1'b1, 32'h1234_5678, 4'h5, 16'd2);
        add_tick(48'd3, 1'b0, 32'h0, 4'h0, 16'd0);
        add_tick(48'd2, 1'b1, 32'hA5A5_A5A5, 4'hA, 16'hFFFF);
        drain();

        // four units, pipelined, full depth
        reg_write(REG_UNITS, 32'd4);
        reg_write(REG_PIPE, 32'd1);
        reg_write(REG_DEPTH, 32'd8);
        sim_cyc = 48'd70000;
        for (int i = 0; i < 12; i++) add_tick(sim_cyc, 1'b1, 32'(i), 4'(i), 16'd5);
        sim_cyc = 48'd70010;
        add_tick(sim_cyc, 1'b0, '0, '0, '0);
        // lower the count with work inflight: retirement still scans all units
        for (int i = 0; i < 8; i++) add_tick(sim_cyc + 48'(i), 1'b1, 32'(100 + i), 4'(i),
                                             16'd4);
        drain();
        reg_write(REG_UNITS, 32'd1);
        reg_write(REG_DEPTH, 32'd0);
        add_tick(sim_cyc + 48'd8, 1'b1, 32'hBEEF, 4'h3, 16'd1);
        add_tick(sim_cyc + 48'd20, 1'b0, '0, '0, '0);
        // completion and ready cycles saturate near the top of the range
        add_tick(M48 - 48'd2, 1'b1, 32'hC0DE, 4'h9, 16'hFFFF);
        add_tick(M48, 1'b1, 32'hD00D, 4'h1, 16'd7);
        drain();

        // random phases over several settings; cycle numbers restart low
        // since the saturated queue entries retire only at the top value
        add_tick(M48, 1'b0, '0, '0, '0);
        drain();
        for (int p = 0; p < 6; p++) begin
            reg_write(REG_UNITS, (p == 0) ? 32'd0 : (p == 5 ? 32'd7 : $urandom_range(1, 4)));
            reg_write(REG_PIPE, p % 2);
            reg_write(REG_DEPTH, (p == 3) ? 32'd15 : $urandom_range(0, 8));
            sim_cyc = 48'(p * 100000 + 1000000);
            // random ticks; the late empty tick after them flushes what they left
            random_phase(49, 12);
            add_tick(sim_cyc + 48'd70000, 1'b0, '0, '0, '0);
            sim_cyc = sim_cyc + 48'd70000;
            if (p == 5) idle_off = 1'b1;
            drain();
        end

        done_flag = 1'b1;
        $display("covered %0d summaries, %0d completions, %0d accepted issues",
                 n_sum, n_cmp, n_acc);
        $display("settings: 0..7 units, blocking and pipelined, depths 0..15, saturation");
        if (errors == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end
endmodule

// File: filelist.f
sv/muit_pkg.sv
sv/muit_slot_ram.sv
sv/multi_unit_issue_tracker_core.sv
dv/tb_top.sv
